### design/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and shared types.
`default_nettype none
package spq_pkg;

    // Number of cells in the row.
    localparam int CAPACITY = 16;
    // Width of the entry counter; it must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Widths fixed by the word format.
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 5;

    // Operation codes of the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Contents of one cell.
    typedef struct packed {
        logic                     valid;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } cell_ctl_t;

endpackage
`default_nettype wire

### design/spq_if.sv
// Valid/ready channel interfaces for command and result words.
`default_nettype none
interface spq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [spq_pkg::TAG_W-1:0]         tag;
    logic signed [spq_pkg::PRIO_W-1:0] prio;

    modport source (output valid, output func, output tag, output prio, input ready);
    modport sink   (input valid, input func, input tag, input prio, output ready);
endinterface

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [spq_pkg::TAG_W-1:0]         out_tag;
    logic signed [spq_pkg::PRIO_W-1:0] out_prio;
    logic [1:0]                        status;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output out_tag, output out_prio, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_tag, input out_prio, input status,
                    input occupancy, output ready);
endinterface
`default_nettype wire

### design/spq_cell.sv
// One cell of the sorted row: holds an entry and trades it with its neighbours.
`default_nettype none
module spq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_later,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    later
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [spq_pkg::TAG_W-1:0]        tag_reg;
    logic [spq_pkg::TAG_W-1:0]        tag_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;

    // A new entry belongs behind this cell's entry unless it beats it strictly,
    // so equal priorities keep their arrival order.
    assign later = !valid_reg || ($signed(prio_reg) < $signed(ctl.prio));

    assign entry.valid = valid_reg;
    assign entry.tag   = tag_reg;
    assign entry.prio  = prio_reg;

    // Keep, take the new entry, take the left neighbour's, or take the right's.
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        if (ctl.insert && later)
        begin
            if (!left_later)
            begin
                valid_next = 1'b1;
                tag_next   = ctl.tag;
                prio_next  = ctl.prio;
            end
            else
            begin
                valid_next = left_entry.valid;
                tag_next   = left_entry.tag;
                prio_next  = left_entry.prio;
            end
        end
        else if (ctl.remove)
        begin
            valid_next = right_entry.valid;
            tag_next   = right_entry.tag;
            prio_next  = right_entry.prio;
        end
    end

    // The valid flag is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule
`default_nettype wire

### design/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: command decode, cell row and result register.
//
//   Channel  Direction  Word fields                            Handshake
//   cmd      in         func, tag, prio                        valid / ready
//   rsp      out        out_tag, out_prio, status, occupancy   valid / ready
//
// For every command, all cells decide their next entry in parallel
// from a signed compare with the broadcast priority and their neighbours' flags.
// One command is accepted per cycle while the result register is empty or being
// drained in the same cycle; a stalled result stalls the command side.
// After reset the queue is empty and usable at once.
`default_nettype none
module sorted_priority_queue_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_cmd_if.sink    cmd,
    spq_rsp_if.source  rsp
);

    localparam logic [spq_pkg::CNT_W-1:0] FULL_COUNT = spq_pkg::CNT_W'(spq_pkg::CAPACITY);

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [spq_pkg::CNT_W-1:0]  count_reg;
    logic [spq_pkg::CNT_W-1:0]  count_next;
    spq_pkg::cell_ctl_t         ctl;
    spq_pkg::entry_t            cells [spq_pkg::CAPACITY];
    logic                       later [spq_pkg::CAPACITY];

    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic [spq_pkg::TAG_W-1:0]         rsp_tag_reg;
    logic [spq_pkg::TAG_W-1:0]         rsp_tag_next;
    logic signed [spq_pkg::PRIO_W-1:0] rsp_prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] rsp_prio_next;
    spq_pkg::status_t                  rsp_status_reg;
    spq_pkg::status_t                  rsp_status_next;
    logic [spq_pkg::OCC_W-1:0]         rsp_occ_reg;
    logic [spq_pkg::OCC_W-1:0]         rsp_occ_next;

    // Accept a word whenever the result register is free or drains now.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);

    // Command broadcast to the row.
    assign ctl.insert = accept && (cmd.func == spq_pkg::FUNC_INSERT) && !full;
    assign ctl.remove = accept && (cmd.func == spq_pkg::FUNC_REMOVE) && !empty;
    assign ctl.tag    = cmd.tag;
    assign ctl.prio   = cmd.prio;

    // Row of cells, the front of the queue in cell 0.
    for (genvar i = 0; i < spq_pkg::CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_later;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_later = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_entry = cells[i-1];
            assign left_later = later[i-1];
        end

        if (i == spq_pkg::CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner_right
            assign right_entry = cells[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_entry  (left_entry),
            .left_later  (left_later),
            .right_entry (right_entry),
            .entry       (cells[i]),
            .later       (later[i])
        );
    end

    // Entry count and the result word of the accepted command.
    always_comb
    begin
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_tag_next    = rsp_tag_reg;
        rsp_prio_next   = rsp_prio_reg;
        rsp_status_next = rsp_status_reg;
        rsp_occ_next    = rsp_occ_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_tag_next   = '0;
            rsp_prio_next  = '0;
            rsp_occ_next   = spq_pkg::OCC_W'(count_next);
            case (cmd.func)
                spq_pkg::FUNC_INSERT:
                begin
                    rsp_status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                end
                spq_pkg::FUNC_REMOVE:
                begin
                    if (empty)
                    begin
                        rsp_status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_status_next = spq_pkg::ST_OK;
                        rsp_tag_next    = cells[0].tag;
                        rsp_prio_next   = cells[0].prio;
                    end
                end
                default:
                begin
                    rsp_status_next = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_tag_reg    <= rsp_tag_next;
        rsp_prio_reg   <= rsp_prio_next;
        rsp_status_reg <= rsp_status_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_tag   = rsp_tag_reg;
    assign rsp.out_prio  = rsp_prio_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.occupancy = rsp_occ_reg;

endmodule
`default_nettype wire

### tb/sv/sorted_priority_queue_top_tb.sv
// Self-checking testbench for the sorted priority queue, with directed and random command words.
`timescale 1ns / 1ps
module sorted_priority_queue_top_tb;

    // One result word as the queue should return it.
    typedef struct packed {
        logic [spq_pkg::TAG_W-1:0]         tag;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        spq_pkg::status_t                  status;
        logic [spq_pkg::OCC_W-1:0]         occ;
    } result_word_t;

    // One row of the directed table; a row may repeat with the tag counting up.
    typedef struct packed {
        logic                              func;
        logic [spq_pkg::TAG_W-1:0]         tag;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        logic [5:0]                        reps;
        logic                              typed;
        result_word_t                      want;
    } step_t;

    logic clk;
    logic rst_n;

    spq_cmd_if cmd_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the queue contents, highest priority at index 0.
    logic [spq_pkg::TAG_W-1:0]         held_tag  [spq_pkg::CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] held_prio [spq_pkg::CAPACITY];
    int                                held_count = 0;

    result_word_t owed_results[$];
    int           mismatches    = 0;
    int           send_idle_pct = 0;
    int           rsp_stall_pct = 0;
    int           hold_left     = 0;

    // Directed words: empty and full cases, the priority extremes and ties.
    localparam int PLAN_LEN = 15;
    localparam step_t PLAN [PLAN_LEN] = '{
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_EMPTY, 5'd0}},
        '{spq_pkg::FUNC_INSERT, 16'hFFFF, 16'sh7FFF, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_OK, 5'd1}},
        '{spq_pkg::FUNC_INSERT, 16'h0000, 16'sh8000, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_OK, 5'd2}},
        '{spq_pkg::FUNC_INSERT, 16'h1234, 16'sh0000, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_OK, 5'd3}},
        '{spq_pkg::FUNC_INSERT, 16'h5678, 16'sh0000, 6'd1,  1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0001, 16'shFFFF, 6'd1,  1'b0, '0},
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd1,  1'b1,
          '{16'hFFFF, 16'sh7FFF, spq_pkg::ST_OK, 5'd4}},
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd4,  1'b0, '0},
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_EMPTY, 5'd0}},
        '{spq_pkg::FUNC_INSERT, 16'hA000, 16'sh0064, 6'd16, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'hBEEF, 16'sh7FFF, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_FULL, 5'd16}},
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd16, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h7FFF, 16'sh0001, 6'd1,  1'b1,
          '{16'h0000, 16'sh0000, spq_pkg::ST_OK, 5'd1}},
        '{spq_pkg::FUNC_INSERT, 16'h8000, 16'sh0002, 6'd1,  1'b0, '0},
        '{spq_pkg::FUNC_REMOVE, 16'h0000, 16'sh0000, 6'd2,  1'b0, '0}
    };

    // Applies one command word to the shadow queue and returns the result it owes.
    function automatic result_word_t predict_queue_op(
        input logic                              f,
        input logic [spq_pkg::TAG_W-1:0]         t,
        input logic signed [spq_pkg::PRIO_W-1:0] p);
        result_word_t w;
        int           pos;
        int           k;
        w = '0;
        w.status = spq_pkg::ST_OK;
        if (f == spq_pkg::FUNC_INSERT)
        begin
            if (held_count >= spq_pkg::CAPACITY)
            begin
                w.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // The new entry goes behind every entry of equal or higher priority.
                pos = 0;
                while (pos < held_count && held_prio[pos] >= p) pos++;
                for (k = held_count; k > pos; k--)
                begin
                    held_tag[k]  = held_tag[k-1];
                    held_prio[k] = held_prio[k-1];
                end
                held_tag[pos]  = t;
                held_prio[pos] = p;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                w.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                w.tag  = held_tag[0];
                w.prio = held_prio[0];
                for (k = 1; k < held_count; k++)
                begin
                    held_tag[k-1]  = held_tag[k];
                    held_prio[k-1] = held_prio[k];
                end
                held_count--;
            end
        end
        w.occ = held_count[spq_pkg::OCC_W-1:0];
        return w;
    endfunction

    // Offers one command word, after an optional random gap, and records what it owes.
    task automatic send_word(input logic f, input logic [spq_pkg::TAG_W-1:0] t,
                             input logic signed [spq_pkg::PRIO_W-1:0] p,
                             input logic typed, input result_word_t want);
        result_word_t pred;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.func  = f;
        cmd_ch.tag   = t;
        cmd_ch.prio  = p;
        do @(posedge clk); while (!cmd_ch.ready);
        pred = predict_queue_op(f, t, p);
        owed_results.push_back(typed ? want : pred);
    endtask

    // Drops valid and waits until every owed result word has come back.
    task automatic wait_all_returned();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
    endtask

    // Random words in runs that lean towards filling, draining or neither.
    task automatic send_random_words(input int count);
        int                                i;
        int                                insert_pct;
        int                                pick;
        logic                              f;
        logic signed [spq_pkg::PRIO_W-1:0] p;
        insert_pct = 50;
        for (i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(2, 0))
                    0: insert_pct = 80;
                    1: insert_pct = 25;
                    default: insert_pct = 50;
                endcase
            end
            f = ($urandom_range(99, 0) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                      : spq_pkg::FUNC_REMOVE;
            // Half the time a narrow band so that ties are common.
            pick = $urandom_range(9, 0);
            if (pick < 5)
                p = spq_pkg::PRIO_W'($urandom_range(8, 0)) - 16'sd4;
            else if (pick < 8)
                p = spq_pkg::PRIO_W'($urandom());
            else
                p = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
            send_word(f, spq_pkg::TAG_W'($urandom()), p, 1'b0, '0);
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, or a long hold-off while hold_left counts down.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready = ($urandom_range(99, 0) >= rsp_stall_pct);
            end
        end
    end

    // Each accepted result word is checked against the oldest owed one.
    always @(posedge clk)
    begin
        result_word_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing owed: tag %h prio %0d status %0d occ %0d",
                       rsp_ch.out_tag, rsp_ch.out_prio, rsp_ch.status, rsp_ch.occupancy);
                mismatches++;
            end
            else
            begin
                exp_w = owed_results.pop_front();
                if (rsp_ch.out_tag !== exp_w.tag)
                begin
                    $error("out_tag mismatch: expected %h, got %h", exp_w.tag, rsp_ch.out_tag);
                    mismatches++;
                end
                if (rsp_ch.out_prio !== exp_w.prio)
                begin
                    $error("out_prio mismatch: expected %0d, got %0d", exp_w.prio,
                           rsp_ch.out_prio);
                    mismatches++;
                end
                if (rsp_ch.status !== exp_w.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", exp_w.status,
                           rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.occupancy !== exp_w.occ)
                begin
                    $error("occupancy mismatch: expected %0d, got %0d", exp_w.occ,
                           rsp_ch.occupancy);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases with varied input idling and result stalls.
    initial
    begin
        int row;
        int r;
        int ph;
        int send_pcts  [4];
        int stall_pcts [4];
        send_pcts  = '{0, 68, 0, 14};
        stall_pcts = '{0, 0, 68, 14};
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func  = spq_pkg::FUNC_INSERT;
        cmd_ch.tag   = '0;
        cmd_ch.prio  = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < PLAN_LEN; row++)
        begin
            for (r = 0; r < PLAN[row].reps; r++)
            begin
                send_word(PLAN[row].func, PLAN[row].tag + spq_pkg::TAG_W'(r),
                          PLAN[row].prio, PLAN[row].typed, PLAN[row].want);
            end
        end
        wait_all_returned();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_pcts[ph];
            rsp_stall_pct = stall_pcts[ph];
            // In the first phase the result side holds off so that the input backs up.
            if (ph == 0) hold_left = 150;
            send_random_words(400);
            wait_all_returned();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
